FILE: rtl/kcc_pkg.sv
// Shared types and constants for the key click classifier.
package kcc_pkg;

    // Widest key port the block supports and bits per lane event code.
    localparam int MAX_KEYS = 8;
    localparam int EV_W     = 3;
    localparam int CFG_W    = 8;
    localparam int CNT_W    = 9;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LONG_CLICK   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_CLICK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_REPEAT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] LONG_CLICK_RST   = 8'd100;
    localparam logic [CFG_W-1:0] SHORT_CLICK_RST  = 8'd5;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 8'd25;
    localparam logic [CFG_W-1:0] LONG_REPEAT_RST  = 8'd10;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Per-lane key phase.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRESS  = 3'd1,
        PH_WAIT   = 3'd2,
        PH_DOUBLE = 3'd3,
        PH_LONG   = 3'd4
    } phase_t;

    // Event code reported by one lane.
    typedef enum logic [EV_W-1:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SHORT  = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_LONG   = 3'd5,
        EV_REPEAT = 3'd6
    } event_t;

    // Timing thresholds shared by all lanes.
    typedef struct packed {
        logic [CFG_W-1:0] long_click;
        logic [CFG_W-1:0] short_click;
        logic [CFG_W-1:0] double_click;
        logic [CFG_W-1:0] long_repeat;
    } cfg_t;

    // Edge and level information for one key on one tick.
    typedef struct packed {
        logic step;
        logic press_edge;
        logic held;
        logic release_edge;
    } lane_in_t;

endpackage

FILE: rtl/kcc_lane.sv
// One key lane: click state machine and hold counter.
module kcc_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  kcc_pkg::cfg_t     cfg,
    input  kcc_pkg::lane_in_t lane_in,
    output kcc_pkg::event_t   ev
);
    import kcc_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic             long_hit;
    logic             short_miss;
    logic             double_over;
    logic             repeat_hit;

    // Saturating increment and threshold compares.
    always_comb
    begin
        count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        long_hit    = count_inc >= CNT_W'(cfg.long_click);
        short_miss  = count_reg < CNT_W'(cfg.short_click);
        double_over = count_inc > CNT_W'(cfg.double_click);
        repeat_hit  = count_inc >= CNT_W'(cfg.long_repeat);
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_PRESS:
            begin
                if (lane_in.held)
                begin
                    if (long_hit)
                    begin
                        phase_next = PH_LONG;
                    end
                end
                else if (short_miss)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (lane_in.press_edge)
                begin
                    phase_next = PH_DOUBLE;
                end
                else if (double_over)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DOUBLE, PH_LONG:
            begin
                if (lane_in.release_edge)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = lane_in.press_edge ? PH_PRESS : PH_IDLE;
            end
        endcase
    end

    // Event and hold counter.
    always_comb
    begin
        ev         = EV_NONE;
        count_next = count_reg;
        case (phase_reg)
            PH_PRESS:
            begin
                if (lane_in.held)
                begin
                    count_next = count_inc;
                    if (long_hit)
                    begin
                        ev         = EV_LONG;
                        count_next = '0;
                    end
                end
                else if (short_miss)
                begin
                    ev = EV_UP;
                end
                else
                begin
                    count_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (lane_in.press_edge)
                begin
                    ev = EV_DOUBLE;
                end
                else
                begin
                    count_next = count_inc;
                    if (double_over)
                    begin
                        ev = EV_SHORT;
                    end
                end
            end
            PH_DOUBLE:
            begin
                if (lane_in.release_edge)
                begin
                    ev = EV_UP;
                end
            end
            PH_LONG:
            begin
                if (lane_in.release_edge)
                begin
                    ev = EV_UP;
                end
                else
                begin
                    count_next = count_inc;
                    if (repeat_hit)
                    begin
                        ev         = EV_REPEAT;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                if (lane_in.press_edge)
                begin
                    ev         = EV_DOWN;
                    count_next = '0;
                end
            end
        endcase
    end

    // State advances only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (lane_in.step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/kcc_merge.sv
// Merge of lane events into one result, with output register and skid stage.
module kcc_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  kcc_pkg::event_t [kcc_pkg::MAX_KEYS-1:0] lane_ev,
    input  logic [kcc_pkg::MAX_KEYS-1:0]           pressed,
    output logic                                   room,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [kcc_pkg::MAX_KEYS*kcc_pkg::EV_W-1:0] key_events,
    output logic [kcc_pkg::MAX_KEYS-1:0]           pressed_now
);
    import kcc_pkg::*;

    localparam int EVT_W  = MAX_KEYS * EV_W;
    localparam int DATA_W = EVT_W + MAX_KEYS;

    logic [DATA_W-1:0] new_data;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] skid_data_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic              out_free;

    // Pack the lane codes side by side with the pressed mask.
    assign new_data = {EVT_W'(lane_ev), pressed};

    assign out_free = !out_valid_reg || out_ready;
    assign room     = !skid_valid_reg;

    // Output stage takes the skid entry first; a stalled output parks the new result.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = new_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = new_data;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_events  = out_data_reg[DATA_W-1:MAX_KEYS];
    assign pressed_now = out_data_reg[MAX_KEYS-1:0];

endmodule

FILE: rtl/key_click_classifier.sv
// Top level of the key click classifier.
//
// Each transfer on the input channel (in_valid/in_ready, raw_port) is one scan
// tick of an active-low key port. Every tick yields exactly one transfer on the
// output channel (out_valid/out_ready, key_events, pressed_now), with a 3-bit
// event code per key and the inverted key mask.
// An accepted tick's result is registered in the output stage, or in the skid
// stage while the output stalls. Throughput is one tick per cycle while in_ready
// is high; the key lanes update their state machines in parallel in the cycle of
// the transfer. The output register is backed by a one-entry skid stage, so a
// tick is still taken while a result waits. When a tick is taken during a stall,
// the skid stage fills and in_ready drops until the output is taken.
// Reset clears both output flags, the previous key mask, every lane to idle
// with a zero hold count, and loads the default thresholds. Configuration
// writes through cfg_we/cfg_index/cfg_wdata take effect at the next edge.
// Lanes at or above NUM_KEYS report no event.
module key_click_classifier #(
    parameter int NUM_KEYS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kcc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [kcc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [kcc_pkg::MAX_KEYS-1:0]       raw_port,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [kcc_pkg::MAX_KEYS*kcc_pkg::EV_W-1:0] key_events,
    output logic [kcc_pkg::MAX_KEYS-1:0]       pressed_now
);
    import kcc_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [MAX_KEYS-1:0]   prev_pressed_reg;
    logic [MAX_KEYS-1:0]   now_pressed;
    logic [MAX_KEYS-1:0]   rise;
    logic [MAX_KEYS-1:0]   fall;
    logic                  accept;
    logic                  room;
    event_t [MAX_KEYS-1:0] lane_ev;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_CLICK:   cfg_next.long_click   = cfg_wdata;
                REG_SHORT_CLICK:  cfg_next.short_click  = cfg_wdata;
                REG_DOUBLE_CLICK: cfg_next.double_click = cfg_wdata;
                REG_LONG_REPEAT:  cfg_next.long_repeat  = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_click   <= LONG_CLICK_RST;
            cfg_reg.short_click  <= SHORT_CLICK_RST;
            cfg_reg.double_click <= DOUBLE_CLICK_RST;
            cfg_reg.long_repeat  <= LONG_REPEAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input transfer and edge detection.
    assign in_ready    = room;
    assign accept      = in_valid && room;
    assign now_pressed = ~raw_port;
    assign rise        = now_pressed & ~prev_pressed_reg;
    assign fall        = prev_pressed_reg & ~now_pressed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pressed_reg <= '0;
        end
        else if (accept)
        begin
            prev_pressed_reg <= now_pressed;
        end
    end

    // Key lanes; unused positions report no event.
    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_lane
        if (i < NUM_KEYS)
        begin : g_used
            lane_in_t lane_in;

            assign lane_in.step         = accept;
            assign lane_in.press_edge   = rise[i];
            assign lane_in.held         = now_pressed[i];
            assign lane_in.release_edge = fall[i];

            kcc_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .cfg     (cfg_reg),
                .lane_in (lane_in),
                .ev      (lane_ev[i])
            );
        end
        else
        begin : g_unused
            assign lane_ev[i] = EV_NONE;
        end
    end

    // Result merge and output buffering.
    kcc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .lane_ev     (lane_ev),
        .pressed     (now_pressed),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_events  (key_events),
        .pressed_now (pressed_now)
    );

endmodule

FILE: rtl/kcc_checker.sv
// Port-level checks for the key click classifier, bound to the top level.
module kcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  raw_port,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] key_events,
    input logic [7:0]  pressed_now
);
    import kcc_pkg::*;

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(key_events) && $stable(pressed_now))
        else $error("result payload changed while stalled");

    // With the output empty, an accepted tick shows up on the output in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid
        |=> out_valid && pressed_now == ~$past(raw_port))
        else $error("tick result missing or wrong pressed mask");

    // An empty output never blocks the input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // A key-down event only appears for a key that is pressed.
    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_lane_chk
        a_down_pressed: assert property (@(posedge clk) disable iff (!rst_n)
            out_valid && key_events[EV_W*i +: EV_W] == EV_DOWN |-> pressed_now[i])
            else $error("down event on a released key");
    end

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .raw_port    (raw_port),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_events  (key_events),
    .pressed_now (pressed_now)
);
